FILE: hw/rtl/eqhc_pkg.sv
// Shared constants, types and helper functions for the equatorial to horizon converter.
// Used by every module in hw/rtl but the checker; depends on nothing else.
`timescale 1ns / 1ps

package eqhc_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int TAB_LEN       = 40;
  localparam int NSTG          = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  // rotation datapath and vectoring datapath widths
  localparam int ROT_W = 34;
  localparam int VEC_W = 36;

  localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;
  localparam logic signed [31:0] NEG_ONE_Q30  = -32'sd1073741824;
  localparam logic signed [63:0] GAIN_INV_Q30 = 64'sd652032874;
  localparam logic signed [63:0] HALF_Q30     = 64'sd536870912;
  localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;

  // configuration register indexes
  localparam logic REG_SIN_LAT = 1'b0;
  localparam logic REG_COS_LAT = 1'b1;

  typedef struct packed {
    logic [31:0] sd;
    logic [31:0] cd;
  } rot_side_t;

  typedef struct packed {
    logic             zero;
    logic [VEC_W-1:0] word;
  } vec_side_t;

  function automatic logic [31:0] atan_val(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // clamp a Q1.30 word into -1.0..1.0
  function automatic logic signed [31:0] sat_q30(input logic [31:0] v);
    logic signed [31:0] s;
    logic signed [31:0] r;
    s = $signed(v);
    if (s > ONE_Q30) r = ONE_Q30;
    else if (s < NEG_ONE_Q30) r = NEG_ONE_Q30;
    else r = s;
    return r;
  endfunction

  // round a Q2.60 product back to Q1.30
  function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v + HALF_Q30;
    return s >>> 30;
  endfunction

endpackage

FILE: hw/rtl/equatorial_to_horizon_convert.sv
// Top level of the equatorial to horizon converter: config registers, product stages, CORDICs.
// Depends on eqhc_pkg, eqhc_cordic_rot and eqhc_cordic_vec.
`timescale 1ns / 1ps

// Usage:
//   Input channel: hour_angle_i (binary angle), sin_declination_i, cos_declination_i
//   (Q1.30), qualified by in_valid_i; an item is taken when in_valid_i is high and
//   in_stall_o is low. Output channel: azimuth_o (unsigned binary angle, north zero,
//   east a quarter turn) and elevation_o (signed binary angle) with out_valid_o,
//   taken when out_valid_o is high and out_stall_i is low.
//   Latitude sine and cosine sit in two APB registers at 0x0 and 0x4; write them
//   only while no item is in flight.
//   Throughput is one item per clock while no held result is stalled. The stages are
//   one sin/cos CORDIC, four multiply/round stages, the azimuth CORDIC, two magnitude
//   stages, the elevation CORDIC and the output register, each CORDIC iteration
//   being one pipeline stage.
//   Reset clears all valid bits and loads sine 0, cosine 1.0 (equator).
//   When the receiver stalls a held result, the whole pipeline freezes and
//   in_stall_o rises; nothing is dropped or repeated.
module equatorial_to_horizon_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] hour_angle_i,
  input  logic [31:0] sin_declination_i,
  input  logic [31:0] cos_declination_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] azimuth_o,
  output logic [31:0] elevation_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW = eqhc_pkg::ROT_W;
  localparam int VW = eqhc_pkg::VEC_W;

  // ---------------- configuration ----------------
  logic [31:0] sin_lat_q, cos_lat_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_lat_q <= 32'd0;
      cos_lat_q <= eqhc_pkg::ONE_Q30;
    end else if (wr_en) begin
      unique case (paddr[2])
        eqhc_pkg::REG_SIN_LAT: sin_lat_q <= pwdata;
        eqhc_pkg::REG_COS_LAT: cos_lat_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      eqhc_pkg::REG_SIN_LAT: prdata = sin_lat_q;
      eqhc_pkg::REG_COS_LAT: prdata = cos_lat_q;
      default:               prdata = '0;
    endcase
  end

  logic signed [31:0] sp, cp;
  assign sp = eqhc_pkg::sat_q30(sin_lat_q);
  assign cp = eqhc_pkg::sat_q30(cos_lat_q);

  // ---------------- flow control ----------------
  logic adv;
  logic out_valid_q;

  assign adv        = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~adv;

  // ---------------- sin/cos of hour angle ----------------
  eqhc_pkg::rot_side_t rot_side_in, rot_side;
  logic                 rot_v, rot_flip;
  logic signed [RW-1:0] rot_c, rot_s;

  assign rot_side_in.sd = eqhc_pkg::sat_q30(sin_declination_i);
  assign rot_side_in.cd = eqhc_pkg::sat_q30(cos_declination_i);

  eqhc_cordic_rot u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .angle_i (hour_angle_i),
    .side_i  (rot_side_in),
    .valid_o (rot_v),
    .cos_o   (rot_c),
    .sin_o   (rot_s),
    .flip_o  (rot_flip),
    .side_o  (rot_side)
  );

  // ---------------- products ----------------
  logic signed [RW-1:0] ch, sh;
  logic signed [31:0]   sd, cd;

  assign ch = rot_flip ? -rot_c : rot_c;
  assign sh = rot_flip ? -rot_s : rot_s;
  assign sd = $signed(rot_side.sd);
  assign cd = $signed(rot_side.cd);

  logic                 m1_v_q, m2_v_q, m3_v_q, m4_v_q;
  logic signed [63:0]   m1_tc_q, m1_sc_q, m1_sdcp_q, m1_sdsp_q;
  logic signed [RW-1:0] m2_t_q;
  logic signed [VW-1:0] m2_y_q, m3_y_q, m4_x_q, m4_y_q, m4_z_q;
  logic signed [63:0]   m2_sdcp_q, m2_sdsp_q, m3_sdcp_q, m3_sdsp_q;
  logic signed [63:0]   m3_tsp_q, m3_tcp_q;
  logic                 m4_zero_q;

  logic signed [63:0] t_full, y_full, x_full, z_full;
  logic signed [VW-1:0] x_d, z_d;

  assign t_full = eqhc_pkg::rnd_q30(m1_tc_q);
  assign y_full = eqhc_pkg::rnd_q30(m1_sc_q);
  assign x_full = eqhc_pkg::rnd_q30(m3_sdcp_q - m3_tsp_q);
  assign z_full = eqhc_pkg::rnd_q30(m3_tcp_q + m3_sdsp_q);
  assign x_d    = VW'(x_full);
  assign z_d    = VW'(z_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= rot_v;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_tc_q   <= 64'(ch) * 64'(cd);
      m1_sc_q   <= 64'(sh) * 64'(cd);
      m1_sdcp_q <= 64'(sd) * 64'(cp);
      m1_sdsp_q <= 64'(sd) * 64'(sp);

      m2_t_q    <= RW'(t_full);
      m2_y_q    <= -VW'(y_full);
      m2_sdcp_q <= m1_sdcp_q;
      m2_sdsp_q <= m1_sdsp_q;

      m3_tsp_q  <= 64'(m2_t_q) * 64'(sp);
      m3_tcp_q  <= 64'(m2_t_q) * 64'(cp);
      m3_y_q    <= m2_y_q;
      m3_sdcp_q <= m2_sdcp_q;
      m3_sdsp_q <= m2_sdsp_q;

      m4_x_q    <= x_d;
      m4_y_q    <= m3_y_q;
      m4_z_q    <= z_d;
      m4_zero_q <= (x_d == '0) && (m3_y_q == '0);
    end
  end

  // ---------------- azimuth CORDIC ----------------
  eqhc_pkg::vec_side_t  v1_side_in, v1_side;
  logic                 v1_v;
  logic signed [VW-1:0] v1_x;
  logic [31:0]          v1_ang;

  assign v1_side_in.zero = m4_zero_q;
  assign v1_side_in.word = m4_z_q;

  eqhc_cordic_vec u_vec_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m4_v_q),
    .x_i     (m4_x_q),
    .y_i     (m4_y_q),
    .side_i  (v1_side_in),
    .valid_o (v1_v),
    .x_o     (v1_x),
    .angle_o (v1_ang),
    .side_o  (v1_side)
  );

  // ---------------- radius ----------------
  logic               g1_v_q, g2_v_q;
  logic signed [63:0] g1_p_q;
  logic [31:0]        g1_ang_q, g2_az_q;
  logic               g1_zero_q, g2_elz_q;
  logic signed [VW-1:0] g1_z_q, g2_r_q, g2_z_q, r_d;

  assign r_d = g1_zero_q ? '0 : VW'(eqhc_pkg::rnd_q30(g1_p_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q <= 1'b0;
      g2_v_q <= 1'b0;
    end else if (adv) begin
      g1_v_q <= v1_v;
      g2_v_q <= g1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g1_p_q    <= 64'(v1_x) * eqhc_pkg::GAIN_INV_Q30;
      g1_ang_q  <= v1_ang;
      g1_zero_q <= v1_side.zero;
      g1_z_q    <= $signed(v1_side.word);

      g2_r_q    <= r_d;
      g2_z_q    <= g1_z_q;
      g2_az_q   <= g1_zero_q ? 32'd0 : g1_ang_q;
      g2_elz_q  <= (r_d == '0) && (g1_z_q == '0);
    end
  end

  // ---------------- elevation CORDIC ----------------
  eqhc_pkg::vec_side_t  v2_side_in, v2_side;
  logic                 v2_v;
  logic signed [VW-1:0] v2_x;
  logic [31:0]          v2_ang;

  assign v2_side_in.zero = g2_elz_q;
  assign v2_side_in.word = VW'(g2_az_q);

  eqhc_cordic_vec u_vec_el (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g2_v_q),
    .x_i     (g2_r_q),
    .y_i     (g2_z_q),
    .side_i  (v2_side_in),
    .valid_o (v2_v),
    .x_o     (v2_x),
    .angle_o (v2_ang),
    .side_o  (v2_side)
  );

  // ---------------- output register ----------------
  logic [31:0] az_q, el_q;
  logic        unused_x;

  // the elevation magnitude is not needed
  assign unused_x = ^v2_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      az_q <= v2_side.word[31:0];
      el_q <= (v2_side.zero | (unused_x & 1'b0)) ? 32'd0 : v2_ang;
    end
  end

  assign out_valid_o = out_valid_q;
  assign azimuth_o   = az_q;
  assign elevation_o = el_q;

endmodule

FILE: hw/rtl/eqhc_cordic_rot.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle, one stage per register.
// Depends on eqhc_pkg.
`timescale 1ns / 1ps

module eqhc_cordic_rot (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [31:0]               angle_i,
  input  eqhc_pkg::rot_side_t       side_i,
  output logic                      valid_o,
  output logic signed [eqhc_pkg::ROT_W-1:0] cos_o,
  output logic signed [eqhc_pkg::ROT_W-1:0] sin_o,
  output logic                      flip_o,
  output eqhc_pkg::rot_side_t       side_o
);

  localparam int N  = eqhc_pkg::NSTG;
  localparam int RW = eqhc_pkg::ROT_W;

  logic                 v_q    [N+1];
  logic signed [RW-1:0] x_q    [N+1];
  logic signed [RW-1:0] y_q    [N+1];
  logic signed [RW-1:0] z_q    [N+1];
  logic                 flip_q [N+1];
  eqhc_pkg::rot_side_t  side_q [N+1];

  logic        flip_d;
  logic [31:0] a_d;

  // fold the left half-plane onto the right one
  assign flip_d = angle_i[31] ^ angle_i[30];
  assign a_d    = flip_d ? (angle_i ^ eqhc_pkg::HALF_TURN) : angle_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= RW'(eqhc_pkg::GAIN_INV_Q30);
      y_q[0]    <= '0;
      z_q[0]    <= RW'($signed(a_d));
      flip_q[0] <= flip_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [31:0] ATAN = eqhc_pkg::atan_val(i);
    logic signed [RW-1:0] dx, dy, tab;
    logic signed [RW-1:0] x_d, y_d, z_d;

    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign tab = RW'(ATAN);

    always_comb begin
      if (!z_q[i][RW-1]) begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - tab;
      end else begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + tab;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        flip_q[i+1] <= flip_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[N];
  assign cos_o   = x_q[N];
  assign sin_o   = y_q[N];
  assign flip_o  = flip_q[N];
  assign side_o  = side_q[N];

endmodule

FILE: hw/rtl/eqhc_cordic_vec.sv
// Pipelined vectoring-mode CORDIC: angle of (x, y) as a binary angle and the scaled magnitude.
// Depends on eqhc_pkg.
`timescale 1ns / 1ps

module eqhc_cordic_vec (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [eqhc_pkg::VEC_W-1:0] x_i,
  input  logic signed [eqhc_pkg::VEC_W-1:0] y_i,
  input  eqhc_pkg::vec_side_t               side_i,
  output logic                              valid_o,
  output logic signed [eqhc_pkg::VEC_W-1:0] x_o,
  output logic [31:0]                       angle_o,
  output eqhc_pkg::vec_side_t               side_o
);

  localparam int N  = eqhc_pkg::NSTG;
  localparam int VW = eqhc_pkg::VEC_W;

  logic                 v_q    [N+1];
  logic signed [VW-1:0] x_q    [N+1];
  logic signed [VW-1:0] y_q    [N+1];
  logic [31:0]          z_q    [N+1];
  eqhc_pkg::vec_side_t  side_q [N+1];

  logic neg_d;
  assign neg_d = x_i[VW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  // mirror the left half-plane and start the angle at a half turn
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= neg_d ? -x_i : x_i;
      y_q[0]    <= neg_d ? -y_i : y_i;
      z_q[0]    <= neg_d ? eqhc_pkg::HALF_TURN : 32'd0;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [31:0] ATAN = eqhc_pkg::atan_val(i);
    logic signed [VW-1:0] dx, dy;
    logic signed [VW-1:0] x_d, y_d;
    logic [31:0]          z_d;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_comb begin
      if (!y_q[i][VW-1]) begin
        x_d = x_q[i] + dx;
        y_d = y_q[i] - dy;
        z_d = z_q[i] + ATAN;
      end else begin
        x_d = x_q[i] - dx;
        y_d = y_q[i] + dy;
        z_d = z_q[i] - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[N];
  assign x_o     = x_q[N];
  assign angle_o = z_q[N];
  assign side_o  = side_q[N];

endmodule

FILE: hw/rtl/eqhc_checker.sv
// Port-level checker for the equatorial to horizon converter, bound to the top level.
// Depends on equatorial_to_horizon_convert port names only.
`timescale 1ns / 1ps

module eqhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] azimuth_o,
  input logic [31:0] elevation_o
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(azimuth_o) && $stable(elevation_o))
    else $error("result changed while stalled");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // nothing comes out right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result offered right after reset");

endmodule

bind equatorial_to_horizon_convert eqhc_checker u_eqhc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .azimuth_o   (azimuth_o),
  .elevation_o (elevation_o)
);

FILE: tb/tb.sv
// Self-checking testbench for equatorial_to_horizon_convert: predicts azimuth and elevation
// per item and compares them in order. Depends on eqhc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb;

  localparam int     STAGES    = (eqhc_pkg::CORDIC_STAGES > 40) ? 40 : eqhc_pkg::CORDIC_STAGES;
  localparam longint UNIT      = 64'sd1073741824;
  localparam longint GAIN_K    = 64'sd652032874;
  localparam int     LATENCY   = 3 * STAGES + 10;
  localparam int     MAX_CYCLE = 600000;
  localparam longint ATAN_BAM [0:39] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  typedef struct {
    logic [31:0] az;
    logic [31:0] el;
  } horizon_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] hour_angle_i = '0;
  logic [31:0] sin_declination_i = '0;
  logic [31:0] cos_declination_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] azimuth_o;
  logic [31:0] elevation_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] lat_sin = 32'd0;
  logic [31:0] lat_cos = 32'd1073741824;
  horizon_t    pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          tx_max = 13;
  int          rx_max = 13;
  int          hold_cycles = 0;

  equatorial_to_horizon_convert dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint clamp_unit(input logic [31:0] v);
    longint s;
    s = longint'($signed(v));
    if (s > UNIT) s = UNIT;
    if (s < -UNIT) s = -UNIT;
    return s;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void rotate_sincos(input logic [31:0] a, output longint s,
                                        output longint c);
    logic   flip;
    longint x, y, z, dx, dy;
    flip = a[31] ^ a[30];
    if (flip) a[31] = ~a[31];
    x = GAIN_K;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_BAM[i];
      end else begin
        x += dx; y -= dy; z += ATAN_BAM[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint vector_angle(input longint x, input longint y,
                                          output longint mag);
    longint z, dx, dy;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_BAM[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_BAM[i];
      end
    end
    mag = round_q30(x * GAIN_K);
    return z;
  endfunction

  function automatic horizon_t horizon_of(input logic [31:0] ha, input logic [31:0] sd_w,
                                          input logic [31:0] cd_w);
    longint   sd, cd, sp, cp, sh, ch, t, x, y, z, r, mag, az, el;
    horizon_t h;
    sd = clamp_unit(sd_w);
    cd = clamp_unit(cd_w);
    sp = clamp_unit(lat_sin);
    cp = clamp_unit(lat_cos);
    rotate_sincos(ha, sh, ch);
    t = round_q30(ch * cd);
    x = round_q30(-t * sp + sd * cp);
    y = -round_q30(sh * cd);
    z = round_q30(t * cp + sd * sp);
    if (x == 0 && y == 0) begin
      az = 0; r = 0;
    end else begin
      az = vector_angle(x, y, r);
    end
    if (r == 0 && z == 0) el = 0;
    else el = vector_angle(r, z, mag);
    h.az = az[31:0];
    h.el = el[31:0];
    return h;
  endfunction

  // predict on every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      pending_q.push_back(horizon_of(hour_angle_i, sin_declination_i, cos_declination_i));
  end

  always @(posedge clk_i) begin
    horizon_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item az=%h el=%h", $time, azimuth_o, elevation_o);
      end else begin
        want = pending_q.pop_front();
        if (azimuth_o !== want.az) begin
          errors++;
          $display("%0t: azimuth expected %h actual %h", $time, want.az, azimuth_o);
        end
        if (elevation_o !== want.el) begin
          errors++;
          $display("%0t: elevation expected %h actual %h", $time, want.el, elevation_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall before each item, or one long hold when requested
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input logic [31:0] ha, input logic [31:0] sd,
                           input logic [31:0] cd);
    int gap;
    gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hour_angle_i      <= ha;
    sin_declination_i <= sd;
    cos_declination_i <= cd;
    in_valid_i        <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_latitude(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == eqhc_pkg::REG_SIN_LAT) lat_sin = value;
    else lat_cos = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] rand_unit();
    logic [31:0] picks [6] = '{32'h4000_0000, 32'hC000_0000, 32'd0,
                               32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0001};
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return picks[$urandom_range(0, 5)];
      default: return 32'(longint'($urandom_range(0, 32'h8000_0000)) - UNIT);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] angles [8] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                                32'h7FFF_FFFF, 32'h3FFF_FFFF, 32'h2000_0000, 32'hFFFF_FFFF};
    // zero vector at the equator, then a pole with no horizontal radius
    send_item(32'h1234_5678, 32'd0, 32'd0);
    send_item(32'h0, 32'h4000_0000, 32'h4000_0000);
    send_item(32'h0, 32'hC000_0000, 32'hC000_0000);
    send_item(32'h9ABC_DEF0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    foreach (angles[i]) send_item(angles[i], 32'h2D41_3CCD, 32'h2D41_3CCD);
    drain();
    write_latitude(eqhc_pkg::REG_SIN_LAT, 32'h4000_0000);
    write_latitude(eqhc_pkg::REG_COS_LAT, 32'h0);
    send_item(32'h5555_5555, 32'h4000_0000, 32'h0);
    send_item(32'h5555_5555, 32'hC000_0000, 32'h0);
    send_item(32'h4000_0000, 32'h0, 32'h4000_0000);
    send_item(32'hC000_0000, 32'h0, 32'hC000_0000);
    drain();
  endtask

  task automatic random_phase(input logic [31:0] sp, input logic [31:0] cp, input int count);
    write_latitude(eqhc_pkg::REG_SIN_LAT, sp);
    write_latitude(eqhc_pkg::REG_COS_LAT, cp);
    for (int i = 0; i < count; i++) begin
      // hold back idling for some stretches
      if (i % 60 == 0) begin
        tx_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
        rx_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      end
      send_item($urandom, rand_unit(), rand_unit());
    end
    drain();
    tx_max = 13;
    rx_max = 13;
  endtask

  task automatic test_latitudes();
    random_phase(32'h0, 32'h4000_0000, 200);
    random_phase(32'h2D41_3CCD, 32'h2D41_3CCD, 200);
    random_phase(32'hC000_0000, 32'h0, 200);
    random_phase(32'h4000_0000, 32'hC000_0000, 150);
    for (int k = 0; k < 3; k++) random_phase(rand_unit(), rand_unit(), 200);
  endtask

  // out-of-range latitude words must clamp
  task automatic test_saturated_latitude();
    random_phase(32'h7FFF_FFFF, 32'h8000_0000, 100);
  endtask

  task automatic test_backpressure();
    tx_max = 0;
    hold_cycles = 400;
    for (int i = 0; i < 250; i++) send_item($urandom, rand_unit(), rand_unit());
    drain();
    tx_max = 13;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_latitudes();
    test_saturated_latitude();
    test_backpressure();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
